>>> rtl/ssb_pkg.sv
// ============================================================================
// ssb_pkg
// Shared types and constants of the scaled sprite blitter.
// ============================================================================
package ssb_pkg;

    // Default limits handed to the top level as parameter defaults.
    localparam int FRAME_DIM_MAX_DEF = 1024;
    localparam int ICON_DIM_MAX_DEF  = 64;
    localparam int SCALE_MAX_DEF     = 8;

    // Field widths fixed by the register map and the word formats.
    localparam int FRAME_CFG_W = 11;
    localparam int ORIGIN_W    = 12;
    localparam int SCALE_W     = 4;
    localparam int ICON_CFG_W  = 7;
    localparam int PIXEL_W     = 16;
    localparam int ADDR_W      = 20;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 12;

    // Internal widths: a clamped frame dimension (up to 4096), a clamped
    // icon dimension (up to 256) and a signed frame coordinate.
    localparam int DIM_W      = 13;
    localparam int ICON_DIM_W = 9;
    localparam int PROD_W     = 12;
    localparam int COORD_W    = 14;

    localparam logic [PIXEL_W-1:0] TRANSPARENT_KEY = 16'h0000;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ICON_WIDTH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ICON_HEIGHT  = 3'd6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLIP,
        ST_BASE,
        ST_EMIT
    } ssb_state_t;

    typedef struct packed {
        logic load;   // take a source pixel and advance the icon position
        logic clip;   // work out the visible rectangle of the block
        logic base;   // compute the first row's start address
        logic step;   // move to the next visible destination pixel
    } ssb_cmd_t;

    typedef struct packed {
        logic visible;  // the block has at least one write
        logic last;     // current write is the final one of the block
    } ssb_status_t;

endpackage

>>> rtl/ssb_if.sv
// ============================================================================
// ssb_pixel_if / ssb_write_if
// Valid-ready channels for source pixels and frame-buffer writes.
// ============================================================================
interface ssb_pixel_if;
    logic        valid;
    logic        ready;
    logic [15:0] source_pixel;

    modport source (output valid, output source_pixel, input ready);
    modport sink   (input valid, input source_pixel, output ready);
endinterface

interface ssb_write_if;
    logic        valid;
    logic        ready;
    logic [19:0] write_address;
    logic [15:0] write_pixel;
    logic        run_last;

    modport source (output valid, output write_address, output write_pixel,
                    output run_last, input ready);
    modport sink   (input valid, input write_address, input write_pixel,
                    input run_last, output ready);
endinterface

>>> rtl/scaled_sprite_blitter.sv
// ============================================================================
// scaled_sprite_blitter
// Replicates each non-black icon pixel into a clipped scale-by-scale block of
// frame-buffer writes.
// ============================================================================
//
//  Channel  Dir  Handshake     Word
//  -------  ---  ------------  ----------------------------------------------
//  src      in   valid/ready   source_pixel (RGB565, raster order)
//  dst      out  valid/ready   write_address, write_pixel, run_last
//  cfg      in   cfg_we        cfg_index selects the register, cfg_data value
//
//  Each source pixel takes three setup steps (accept, clip, row address)
//  and then one step per visible write; the walk over the clipped block in
//  the datapath gives one write a cycle while dst is ready. A stall on dst
//  holds the current write and the walk.
//  Reset loads the register defaults and puts the icon position at column 0,
//  row 0. One pixel is in flight at a time; src is ready only when idle.
//
module scaled_sprite_blitter #(
    parameter int FRAME_DIM_MAX = ssb_pkg::FRAME_DIM_MAX_DEF,
    parameter int ICON_DIM_MAX  = ssb_pkg::ICON_DIM_MAX_DEF,
    parameter int SCALE_MAX     = ssb_pkg::SCALE_MAX_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    ssb_pixel_if.sink                      src,
    ssb_write_if.source                    dst,
    input  logic                           cfg_we,
    input  logic [ssb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ssb_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ssb_pkg::*;

    // Commands from the sequencer and status back from the datapath are the
    // only links between the two halves.
    ssb_cmd_t    cmd;
    ssb_status_t status;

    ssb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (src.valid),
        .in_ready  (src.ready),
        .out_valid (dst.valid),
        .out_ready (dst.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the registers, the icon position, the clipped
    // window and the address walk; the output word comes straight from its
    // registers so it holds steady under a stall.
    ssb_datapath #(
        .FRAME_DIM_MAX (FRAME_DIM_MAX),
        .ICON_DIM_MAX  (ICON_DIM_MAX),
        .SCALE_MAX     (SCALE_MAX)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .status        (status),
        .source_pixel  (src.source_pixel),
        .write_address (dst.write_address),
        .write_pixel   (dst.write_pixel),
        .run_last      (dst.run_last)
    );

endmodule

>>> rtl/ssb_ctrl.sv
// ============================================================================
// ssb_ctrl
// Sequencer: accept a pixel, clip its block, then emit the visible writes.
// ============================================================================
module ssb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  ssb_pkg::ssb_status_t status,
    output ssb_pkg::ssb_cmd_t    cmd
);
    import ssb_pkg::*;

    ssb_state_t state_reg;
    ssb_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CLIP;
                end
            end
            ST_CLIP:
            begin
                cmd.clip   = 1'b1;
                state_next = ST_BASE;
            end
            ST_BASE:
            begin
                cmd.base   = 1'b1;
                state_next = status.visible ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.step = 1'b1;
                    if (status.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/ssb_datapath.sv
// ============================================================================
// ssb_datapath
// Configuration registers, icon position, clip window and address walk.
// ============================================================================
module ssb_datapath #(
    parameter int FRAME_DIM_MAX = ssb_pkg::FRAME_DIM_MAX_DEF,
    parameter int ICON_DIM_MAX  = ssb_pkg::ICON_DIM_MAX_DEF,
    parameter int SCALE_MAX     = ssb_pkg::SCALE_MAX_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ssb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ssb_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  ssb_pkg::ssb_cmd_t                 cmd,
    output ssb_pkg::ssb_status_t              status,
    input  logic [ssb_pkg::PIXEL_W-1:0]       source_pixel,
    output logic [ssb_pkg::ADDR_W-1:0]        write_address,
    output logic [ssb_pkg::PIXEL_W-1:0]       write_pixel,
    output logic                              run_last
);
    import ssb_pkg::*;

    localparam int COL_W = (ICON_DIM_MAX > 1) ? $clog2(ICON_DIM_MAX) : 1;
    localparam logic [DIM_W-1:0]      FRAME_LIM = DIM_W'(FRAME_DIM_MAX);
    localparam logic [ICON_DIM_W-1:0] ICON_LIM  = ICON_DIM_W'(ICON_DIM_MAX);
    localparam logic [SCALE_W-1:0]    SCALE_LIM = SCALE_W'(SCALE_MAX);

    // Configuration registers.
    logic [FRAME_CFG_W-1:0]     frame_width_reg;
    logic [FRAME_CFG_W-1:0]     frame_height_reg;
    logic signed [ORIGIN_W-1:0] origin_x_reg;
    logic signed [ORIGIN_W-1:0] origin_y_reg;
    logic [SCALE_W-1:0]         scale_reg;
    logic [ICON_CFG_W-1:0]      icon_width_reg;
    logic [ICON_CFG_W-1:0]      icon_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_CFG_W'(480);
            frame_height_reg <= FRAME_CFG_W'(800);
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            scale_reg        <= SCALE_W'(1);
            icon_width_reg   <= ICON_CFG_W'(64);
            icon_height_reg  <= ICON_CFG_W'(64);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FRAME_CFG_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FRAME_CFG_W-1:0];
                REG_ORIGIN_X:     origin_x_reg     <= cfg_data[ORIGIN_W-1:0];
                REG_ORIGIN_Y:     origin_y_reg     <= cfg_data[ORIGIN_W-1:0];
                REG_SCALE:        scale_reg        <= cfg_data[SCALE_W-1:0];
                REG_ICON_WIDTH:   icon_width_reg   <= cfg_data[ICON_CFG_W-1:0];
                REG_ICON_HEIGHT:  icon_height_reg  <= cfg_data[ICON_CFG_W-1:0];
                default:          ;
            endcase
        end
    end

    // Clamped working values.
    logic [DIM_W-1:0]      fw;
    logic [DIM_W-1:0]      fh;
    logic [SCALE_W-1:0]    sc;
    logic [ICON_DIM_W-1:0] iw;
    logic [ICON_DIM_W-1:0] ih;
    logic [DIM_W-1:0]      fw_raw;
    logic [DIM_W-1:0]      fh_raw;
    logic [ICON_DIM_W-1:0] iw_raw;
    logic [ICON_DIM_W-1:0] ih_raw;

    always_comb
    begin
        fw_raw = DIM_W'(frame_width_reg);
        fh_raw = DIM_W'(frame_height_reg);
        iw_raw = ICON_DIM_W'(icon_width_reg);
        ih_raw = ICON_DIM_W'(icon_height_reg);
        fw = (fw_raw > FRAME_LIM) ? FRAME_LIM : fw_raw;
        fh = (fh_raw > FRAME_LIM) ? FRAME_LIM : fh_raw;
        if (scale_reg == '0)
            sc = SCALE_W'(1);
        else
            sc = (scale_reg > SCALE_LIM) ? SCALE_LIM : scale_reg;
        if (iw_raw == '0)
            iw = ICON_DIM_W'(1);
        else
            iw = (iw_raw > ICON_LIM) ? ICON_LIM : iw_raw;
        if (ih_raw == '0)
            ih = ICON_DIM_W'(1);
        else
            ih = (ih_raw > ICON_LIM) ? ICON_LIM : ih_raw;
    end

    // Icon position and the per-pixel block offsets.
    logic [COL_W-1:0]      col_reg;
    logic [COL_W-1:0]      row_reg;
    logic [ICON_DIM_W-1:0] col_inc;
    logic [ICON_DIM_W-1:0] row_inc;
    logic [PROD_W-1:0]     prodx_reg;
    logic [PROD_W-1:0]     prody_reg;
    logic [PIXEL_W-1:0]    pixel_reg;

    assign col_inc = ICON_DIM_W'(col_reg) + ICON_DIM_W'(1);
    assign row_inc = ICON_DIM_W'(row_reg) + ICON_DIM_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cmd.load)
        begin
            if (col_inc >= iw)
            begin
                col_reg <= '0;
                row_reg <= (row_inc >= ih) ? '0 : row_inc[COL_W-1:0];
            end
            else
            begin
                col_reg <= col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            prodx_reg <= PROD_W'(col_reg) * PROD_W'(sc);
            prody_reg <= PROD_W'(row_reg) * PROD_W'(sc);
            pixel_reg <= source_pixel;
        end
    end

    // Visible window of the block, clipped against the frame buffer.
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [COORD_W-1:0] bxe;
    logic signed [COORD_W-1:0] bye;
    logic signed [COORD_W-1:0] fw_s;
    logic signed [COORD_W-1:0] fh_s;
    logic signed [COORD_W-1:0] xs;
    logic signed [COORD_W-1:0] ys;
    logic signed [COORD_W-1:0] xe;
    logic signed [COORD_W-1:0] ye;

    always_comb
    begin
        bx   = COORD_W'(origin_x_reg) + signed'(COORD_W'(prodx_reg));
        by   = COORD_W'(origin_y_reg) + signed'(COORD_W'(prody_reg));
        bxe  = bx + signed'(COORD_W'(sc));
        bye  = by + signed'(COORD_W'(sc));
        fw_s = signed'(COORD_W'(fw));
        fh_s = signed'(COORD_W'(fh));
        xs   = (bx < 0) ? '0 : bx;
        ys   = (by < 0) ? '0 : by;
        xe   = (bxe > fw_s) ? fw_s : bxe;
        ye   = (bye > fh_s) ? fh_s : bye;
    end

    logic signed [COORD_W-1:0] xs_reg;
    logic signed [COORD_W-1:0] xe_reg;
    logic signed [COORD_W-1:0] ye_reg;
    logic signed [COORD_W-1:0] x_reg;
    logic signed [COORD_W-1:0] y_reg;
    logic                      visible_reg;
    logic [ADDR_W-1:0]         row_base_reg;
    logic [2*DIM_W-1:0]        base_prod;

    assign base_prod = y_reg[DIM_W-1:0] * fw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visible_reg <= 1'b0;
        end
        else if (cmd.clip)
        begin
            visible_reg <= (xs < xe) && (ys < ye) && (pixel_reg != TRANSPARENT_KEY);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clip)
        begin
            xs_reg <= xs;
            xe_reg <= xe;
            ye_reg <= ye;
            x_reg  <= xs;
            y_reg  <= ys;
        end
        else if (cmd.base)
        begin
            row_base_reg <= base_prod[ADDR_W-1:0];
        end
        else if (cmd.step)
        begin
            if (x_reg == xe_reg - COORD_W'(1))
            begin
                x_reg        <= xs_reg;
                y_reg        <= y_reg + COORD_W'(1);
                row_base_reg <= row_base_reg + ADDR_W'(fw);
            end
            else
            begin
                x_reg <= x_reg + COORD_W'(1);
            end
        end
    end

    assign status.visible = visible_reg;
    assign status.last    = (x_reg == xe_reg - COORD_W'(1)) &&
                            (y_reg == ye_reg - COORD_W'(1));

    assign write_address = row_base_reg + ADDR_W'(x_reg[DIM_W-1:0]);
    assign write_pixel   = pixel_reg;
    assign run_last      = status.last;

endmodule

>>> tb/tb_scaled_sprite_blitter.sv
// ============================================================================
// tb_scaled_sprite_blitter
// Self-checking testbench for the scaled sprite blitter.
// ============================================================================
// Every source word that the block accepts goes through a predictor that
// keeps its own copy of the registers and of the icon position. The predictor
// expands the word into the clipped block of frame-buffer writes it should
// cause. A checker process pops those writes in order as the destination
// channel delivers them. A directed part covers the corner cases. A random
// part then draws icons under many layouts, with three idling patterns on
// the two channels.
// ============================================================================
module tb_scaled_sprite_blitter;
    timeunit 1ns;
    timeprecision 1ps;

    import ssb_pkg::*;

    localparam int FRAME_MAX = FRAME_DIM_MAX_DEF;
    localparam int ICON_MAX  = ICON_DIM_MAX_DEF;
    localparam int SCALE_LIM = SCALE_MAX_DEF;

    // A source word whose writes are all clipped, or that is black, still
    // keeps the block busy through its clip and row-address steps. This settle
    // time covers those steps, so the block is at rest before any register write.
    localparam int SETTLE_CYCLES = SCALE_LIM * SCALE_LIM + 8;

    // The slowest correct run is about 200 words of 64 writes, each write
    // held by random receiver stalls. That is well below this limit.
    localparam int CYCLE_LIMIT = 1_500_000;

    // Least number of random source words in each of the three idling phases.
    localparam int PHASE_WORDS = 45;

    localparam int FRAME_CFG_MAX = (1 << FRAME_CFG_W) - 1;
    localparam int SCALE_CFG_MAX = (1 << SCALE_W) - 1;
    localparam int ICON_CFG_MAX  = (1 << ICON_CFG_W) - 1;

    // One expected frame-buffer write, as the destination word carries it.
    typedef struct packed {
        logic [ADDR_W-1:0]  address;
        logic [PIXEL_W-1:0] pixel;
        logic               last;
    } fb_write_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ssb_pixel_if src_ch();
    ssb_write_if dst_ch();

    scaled_sprite_blitter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src       (src_ch),
        .dst       (dst_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Shadow copy of the registers, at the widths the block stores them.
    logic [FRAME_CFG_W-1:0] frame_w_reg;
    logic [FRAME_CFG_W-1:0] frame_h_reg;
    logic [ORIGIN_W-1:0]    origin_x_reg;
    logic [ORIGIN_W-1:0]    origin_y_reg;
    logic [SCALE_W-1:0]     scale_reg;
    logic [ICON_CFG_W-1:0]  icon_w_reg;
    logic [ICON_CFG_W-1:0]  icon_h_reg;

    // Predicted icon position, advanced on every accepted source word.
    logic [5:0] icon_col;
    logic [5:0] icon_row;

    fb_write_t   pending_writes[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int unsigned src_idle_pct;
    int unsigned dst_idle_pct;
    bit          block_touched = 1'b0;

    // A zero dimension behaves as one and anything above the limit saturates.
    function automatic int clamp_dim(input int value, input int limit);
        if (value == 0)
            return 1;
        return (value > limit) ? limit : value;
    endfunction

    // Expands one accepted source word into the writes it should cause and
    // then steps the icon position, wrapping column and row.
    task automatic predict_block_writes(input logic [PIXEL_W-1:0] px);
        int        fw;
        int        fh;
        int        sc;
        int        iw;
        int        ih;
        int        base_x;
        int        base_y;
        int        fx;
        int        fy;
        int        n;
        fb_write_t w;
        fw = (int'(frame_w_reg) > FRAME_MAX) ? FRAME_MAX : int'(frame_w_reg);
        fh = (int'(frame_h_reg) > FRAME_MAX) ? FRAME_MAX : int'(frame_h_reg);
        sc = clamp_dim(int'(scale_reg), SCALE_LIM);
        iw = clamp_dim(int'(icon_w_reg), ICON_MAX);
        ih = clamp_dim(int'(icon_h_reg), ICON_MAX);
        n = 0;
        if (px != TRANSPARENT_KEY)
        begin
            base_x = int'($signed(origin_x_reg)) + int'(icon_col) * sc;
            base_y = int'($signed(origin_y_reg)) + int'(icon_row) * sc;
            for (int dy = 0; dy < sc; dy++)
            begin
                fy = base_y + dy;
                if (fy >= 0 && fy < fh)
                begin
                    for (int dx = 0; dx < sc; dx++)
                    begin
                        fx = base_x + dx;
                        if (fx >= 0 && fx < fw)
                        begin
                            w.address = ADDR_W'(fy * fw + fx);
                            w.pixel   = px;
                            w.last    = 1'b0;
                            pending_writes.push_back(w);
                            n++;
                        end
                    end
                end
            end
            // Only the final surviving write of the block is marked.
            if (n > 0)
            begin
                w = pending_writes.pop_back();
                w.last = 1'b1;
                pending_writes.push_back(w);
            end
        end
        // The position may sit past a lowered icon size; it then wraps.
        if (int'(icon_col) + 1 >= iw)
        begin
            icon_col = '0;
            icon_row = (int'(icon_row) + 1 >= ih) ? '0 : icon_row + 1'b1;
        end
        else
        begin
            icon_col = icon_col + 1'b1;
        end
    endtask

    task automatic report(input string what);
        if (mismatch_count < 100)
            $display("ERROR at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // Offers one source word, after a random idle gap, and predicts its
    // writes once it is taken. The valid stays high after the handshake so
    // that a following word can go out back to back; the next call or the
    // idle wait decides whether it drops.
    task automatic send_pixel(input logic [PIXEL_W-1:0] px);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            src_ch.valid <= 1'b0;
            @(posedge clk);
        end
        src_ch.valid        <= 1'b1;
        src_ch.source_pixel <= px;
        @(posedge clk);
        while (!src_ch.ready)
            @(posedge clk);
        predict_block_writes(px);
        block_touched = 1'b1;
    endtask

    // Brings the block to rest. The queue must drain first. Then a settle
    // time covers a word whose writes were all clipped or that was black.
    task automatic wait_idle();
        if (block_touched)
        begin
            src_ch.valid <= 1'b0;
            while (pending_writes.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
            block_touched = 1'b0;
        end
    endtask

    // Register writes happen only with the block at rest.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'(value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_FRAME_WIDTH:  frame_w_reg  = data[FRAME_CFG_W-1:0];
            REG_FRAME_HEIGHT: frame_h_reg  = data[FRAME_CFG_W-1:0];
            REG_ORIGIN_X:     origin_x_reg = data[ORIGIN_W-1:0];
            REG_ORIGIN_Y:     origin_y_reg = data[ORIGIN_W-1:0];
            REG_SCALE:        scale_reg    = data[SCALE_W-1:0];
            REG_ICON_WIDTH:   icon_w_reg   = data[ICON_CFG_W-1:0];
            REG_ICON_HEIGHT:  icon_h_reg   = data[ICON_CFG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_layout(input int fw, input int fh, input int ox, input int oy,
                              input int sc, input int iw, input int ih);
        write_reg(REG_FRAME_WIDTH, fw);
        write_reg(REG_FRAME_HEIGHT, fh);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_SCALE, sc);
        write_reg(REG_ICON_WIDTH, iw);
        write_reg(REG_ICON_HEIGHT, ih);
    endtask

    // Frame sizes lean toward ordinary values but include zero, one, the
    // limit itself and values above it that must saturate.
    function automatic int pick_frame_dim();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 0;
        if (r == 1)
            return int'($urandom_range(FRAME_MAX + 1, FRAME_CFG_MAX));
        if (r == 2)
            return 1;
        if (r == 3)
            return FRAME_MAX;
        return int'($urandom_range(16, FRAME_MAX));
    endfunction

    // Reset values: 480 by 800 frame, origin at zero, scale one, 64 by 64
    // icon. Black must give no writes, and the other words one each.
    task automatic test_reset_defaults();
        send_pixel(16'hFFFF);
        send_pixel(TRANSPARENT_KEY);
        send_pixel(16'h0001);
        send_pixel(16'h8000);
    endtask

    // A zero scale must act as one, the limit gives a full block of writes
    // and anything above the limit saturates to it.
    task automatic test_scale_limits();
        write_reg(REG_ORIGIN_X, 4);
        write_reg(REG_ORIGIN_Y, 4);
        write_reg(REG_SCALE, 0);
        send_pixel(16'h7BEF);
        write_reg(REG_SCALE, SCALE_LIM);
        send_pixel(16'hFFFF);
        write_reg(REG_SCALE, SCALE_CFG_MAX);
        send_pixel(16'h001F);
    endtask

    // Clipping at every edge. The origins are computed from the predicted
    // position so that the scale-4 block lands where we want it.
    task automatic test_frame_clipping();
        // Oversized frame saturates; the block straddles the bottom-right
        // corner of the saturated frame, so only a 3 by 3 corner survives.
        set_layout(FRAME_CFG_MAX, FRAME_CFG_MAX, FRAME_MAX - 3 - int'(icon_col) * 4,
                   FRAME_MAX - 3 - int'(icon_row) * 4, 4, ICON_MAX, ICON_MAX);
        send_pixel(16'hF800);
        // Most negative origin: the whole block falls off the top left.
        write_reg(REG_ORIGIN_X, -2048);
        write_reg(REG_ORIGIN_Y, -2048);
        send_pixel(16'h07E0);
        // Most positive origin: the whole block falls off the bottom right.
        write_reg(REG_ORIGIN_X, 2047);
        write_reg(REG_ORIGIN_Y, 2047);
        send_pixel(16'h001F);
        // One-column frame with a block that hangs over the left and top.
        set_layout(1, FRAME_MAX, -2 - int'(icon_col) * 4, -1 - int'(icon_row) * 4,
                   4, ICON_MAX, ICON_MAX);
        send_pixel(16'hABCD);
        // A zero width or a zero height clips every write.
        set_layout(0, 800, 0, 0, 1, ICON_MAX, ICON_MAX);
        send_pixel(16'h5555);
        write_reg(REG_FRAME_WIDTH, 480);
        write_reg(REG_FRAME_HEIGHT, 0);
        send_pixel(16'hAAAA);
    endtask

    // Icon sizes of zero and above the limit, and sizes lowered below the
    // stored position, which must still draw there and then wrap.
    task automatic test_icon_position();
        set_layout(FRAME_MAX, FRAME_MAX, 0, 0, 2, ICON_MAX, ICON_MAX);
        send_pixel(16'h1234);
        send_pixel(TRANSPARENT_KEY);
        // A zero width acts as one and the column is already past it.
        write_reg(REG_ICON_WIDTH, 0);
        write_reg(REG_ICON_HEIGHT, ICON_CFG_MAX);
        send_pixel(16'h4321);
        send_pixel(16'hFEDC);
        write_reg(REG_ICON_WIDTH, 3);
        write_reg(REG_ICON_HEIGHT, 2);
        repeat (4) send_pixel(16'h0F0F);
        // A height of one moves the row back to zero on the next wrap.
        write_reg(REG_ICON_HEIGHT, 1);
        send_pixel(16'hF0F0);
        send_pixel(16'h0001);
    endtask

    // Random icons, mostly complete and small, each under a fresh layout.
    // Some icons are cut short or have odd sizes, so the next one starts
    // at a position the layout did not expect.
    task automatic test_random_icons(input int unsigned src_pct, input int unsigned dst_pct);
        int                 sent;
        int                 fw;
        int                 fh;
        int                 span;
        int                 ox;
        int                 oy;
        int                 sc;
        int                 iw;
        int                 ih;
        int                 words;
        int unsigned        r;
        logic [PIXEL_W-1:0] px;
        src_idle_pct = src_pct;
        dst_idle_pct = dst_pct;
        sent = 0;
        while (sent < PHASE_WORDS)
        begin
            fw = pick_frame_dim();
            fh = pick_frame_dim();
            // Origins mostly land near the frame so that partial clipping
            // is common; now and then any 12-bit value is used.
            span = (fw == 0) ? 64 : ((fw > FRAME_MAX) ? FRAME_MAX : fw);
            if ($urandom_range(0, 9) == 0)
                ox = int'($urandom_range(0, 4095));
            else
                ox = int'($urandom_range(0, span + 16)) - 16;
            span = (fh == 0) ? 64 : ((fh > FRAME_MAX) ? FRAME_MAX : fh);
            if ($urandom_range(0, 9) == 0)
                oy = int'($urandom_range(0, 4095));
            else
                oy = int'($urandom_range(0, span + 16)) - 16;
            r = $urandom_range(0, 9);
            if (r == 0)
                sc = 0;
            else if (r == 1)
                sc = int'($urandom_range(SCALE_LIM, SCALE_CFG_MAX));
            else
                sc = int'($urandom_range(1, 4));
            if ($urandom_range(0, 9) == 0)
            begin
                iw = int'($urandom_range(0, ICON_CFG_MAX));
                ih = int'($urandom_range(0, ICON_CFG_MAX));
            end
            else
            begin
                iw = int'($urandom_range(1, 6));
                ih = int'($urandom_range(1, 4));
            end
            set_layout(fw, fh, ox, oy, sc, iw, ih);
            words = clamp_dim(iw, ICON_MAX) * clamp_dim(ih, ICON_MAX);
            if (words > 24)
                words = 24;
            if ($urandom_range(0, 5) == 0)
                words = int'($urandom_range(1, words));
            repeat (words)
            begin
                r = $urandom_range(0, 19);
                if (r < 5)
                    px = TRANSPARENT_KEY;
                else if (r == 5)
                    px = 16'hFFFF;
                else
                    px = PIXEL_W'($urandom_range(0, 65535));
                send_pixel(px);
            end
            sent += words;
        end
    endtask

    // The receiver stalls at random, at the rate of the current phase.
    always @(posedge clk)
        dst_ch.ready <= ($urandom_range(0, 99) >= dst_idle_pct);

    // Every delivered write word is checked against the oldest expectation.
    always @(posedge clk)
    begin
        fb_write_t exp_w;
        if (rst_n && dst_ch.valid && dst_ch.ready)
        begin
            if (pending_writes.size() == 0)
            begin
                report($sformatf("unexpected write address %0h pixel %0h last %0b",
                                 dst_ch.write_address, dst_ch.write_pixel, dst_ch.run_last));
            end
            else
            begin
                exp_w = pending_writes.pop_front();
                if (dst_ch.write_address !== exp_w.address)
                    report($sformatf("write_address %0h, expected %0h",
                                     dst_ch.write_address, exp_w.address));
                if (dst_ch.write_pixel !== exp_w.pixel)
                    report($sformatf("write_pixel %0h, expected %0h",
                                     dst_ch.write_pixel, exp_w.pixel));
                if (dst_ch.run_last !== exp_w.last)
                    report($sformatf("run_last %0b, expected %0b",
                                     dst_ch.run_last, exp_w.last));
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        src_ch.valid        = 1'b0;
        src_ch.source_pixel = '0;
        frame_w_reg         = 11'd480;
        frame_h_reg         = 11'd800;
        origin_x_reg        = '0;
        origin_y_reg        = '0;
        scale_reg           = 4'd1;
        icon_w_reg          = 7'd64;
        icon_h_reg          = 7'd64;
        icon_col            = '0;
        icon_row            = '0;
        src_idle_pct        = 38;
        dst_idle_pct        = 64;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_scale_limits();
        test_frame_clipping();
        test_icon_position();
        test_random_icons(38, 64);
        test_random_icons(64, 38);
        test_random_icons(0, 0);
        wait_idle();

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
